FILE: rtl/memory_to_memory_instruction_stepper_assert.svh
// Assertion macros used by the instruction stepper controller.
`ifndef MEMORY_TO_MEMORY_INSTRUCTION_STEPPER_ASSERT_SVH
`define MEMORY_TO_MEMORY_INSTRUCTION_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define MMIS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MMIS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMIS_ASSERT_SAME(lbl, ante, cons, msg)
`define MMIS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/mmis_pkg.sv
// Shared constants, codes, types and helpers of the instruction stepper.
package mmis_pkg;
    localparam int DATA_WORDS    = 256;
    localparam int PROGRAM_WORDS = 512;
    localparam int DA_W  = $clog2(DATA_WORDS);
    localparam int PA_W  = $clog2(PROGRAM_WORDS);
    localparam int PC_W  = PA_W + 1;
    localparam int TGT_W = ((PC_W > 10) ? PC_W : 10) + 2;

    localparam logic [1:0] OPN_LOAD   = 2'd0;
    localparam logic [1:0] OPN_STEP   = 2'd1;
    localparam logic [1:0] OPN_REWIND = 2'd2;
    localparam logic [1:0] OPN_CLEAR  = 2'd3;

    localparam logic [3:0] OPC_ADD   = 4'd0;
    localparam logic [3:0] OPC_SUB   = 4'd1;
    localparam logic [3:0] OPC_MUL   = 4'd2;
    localparam logic [3:0] OPC_DIV   = 4'd3;
    localparam logic [3:0] OPC_POW   = 4'd4;
    localparam logic [3:0] OPC_READ  = 4'd5;
    localparam logic [3:0] OPC_PRINT = 4'd6;
    localparam logic [3:0] OPC_STORE = 4'd7;
    localparam logic [3:0] OPC_JUMP  = 4'd8;
    localparam logic [3:0] OPC_JEQ   = 4'd9;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DIV0   = 2'd2;
    localparam logic [1:0] ST_HALTED = 2'd3;

    typedef struct packed {
        logic [7:0]  c;
        logic [31:0] b;
        logic [9:0]  a;
        logic [3:0]  op;
    } t_instr;

    typedef struct packed {
        logic capture;
        logic simple;
        logic fetch;
        logic rdops;
        logic iter_start;
        logic exec;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] operation;
        logic       halted;
        logic       needs_iter;
        logic       iter_done;
        logic       out_full;
    } t_sts;

    // Data address: low byte of a field, wrapped to the data memory depth.
    function automatic logic [DA_W-1:0] addr_of(input logic [7:0] v);
        return DA_W'(v);
    endfunction
endpackage

FILE: rtl/mmis_iter.sv
// Multi-cycle unit: restoring signed division and saturating integer power.
module mmis_iter
    import mmis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_is_pow,
    input  logic [31:0] i_x,
    input  logic [31:0] i_y,
    output logic        o_done,
    output logic [31:0] o_result
);
    logic        r_busy, r_pow, r_phase, r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [31:0] r_quo, r_dmag, r_mag, r_exp, r_res;
    logic [63:0] r_prod;
    logic        r_qneg, r_sgn, r_bneg, r_negf;

    logic [32:0] trial;
    logic        nsgn, ovf;
    logic [63:0] limit;

    always_comb begin
        trial = {r_rem[31:0], r_quo[31]} - {1'b0, r_dmag};
        nsgn  = r_sgn ^ r_bneg;
        limit = nsgn ? 64'h8000_0000 : 64'h7FFF_FFFF;
        ovf   = r_prod > limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_pow   <= i_is_pow;
                r_phase <= 1'b0;
                r_cnt   <= 6'd0;
                r_rem   <= 33'd0;
                r_quo   <= i_x[31] ? -i_x : i_x;
                r_dmag  <= i_y[31] ? -i_y : i_y;
                r_qneg  <= i_x[31] ^ i_y[31];
                r_mag   <= 32'd1;
                r_exp   <= i_y;
                r_sgn   <= 1'b0;
                r_bneg  <= i_x[31];
                r_negf  <= i_x[31] & i_y[0];
            end else if (r_busy && !r_pow) begin
                // One quotient bit a cycle.
                if (!trial[32]) begin
                    r_rem <= trial;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_quo[31]};
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (!trial[32]) begin
                        r_res <= r_qneg ? -{r_quo[30:0], 1'b1} : {r_quo[30:0], 1'b1};
                    end else begin
                        r_res <= r_qneg ? -{r_quo[30:0], 1'b0} : {r_quo[30:0], 1'b0};
                    end
                end
            end else if (r_busy) begin
                // Multiply by the base magnitude into the product register, check the range in the next cycle.
                r_phase <= ~r_phase;
                if (!r_phase) begin
                    r_prod <= r_mag * r_quo;
                end else if (ovf) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= r_negf ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    r_mag <= r_prod[31:0];
                    r_sgn <= nsgn;
                    r_exp <= r_exp - 32'd1;
                    if (r_exp == 32'd1) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_res  <= nsgn ? -r_prod[31:0] : r_prod[31:0];
                    end
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule

FILE: rtl/mmis_ctrl.sv
// Controller state machine sequencing each item through the datapath.
`include "memory_to_memory_instruction_stepper_assert.svh"
module mmis_ctrl
    import mmis_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RDOP = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.operation != OPN_STEP || i_sts.halted) begin
                    o_cmd.simple = 1'b1;
                    n_state = S_FIN;
                end else begin
                    o_cmd.fetch = 1'b1;
                    n_state = S_RDOP;
                end
            end
            S_RDOP: begin
                o_cmd.rdops = 1'b1;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.needs_iter) begin
                    o_cmd.iter_start = 1'b1;
                    n_state = S_WAIT;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_WAIT: begin
                if (i_sts.iter_done) begin
                    o_cmd.exec = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MMIS_ASSERT_NEXT(a_start_waits, o_cmd.iter_start, r_state == S_WAIT, "unit start left wait")
    `MMIS_ASSERT_SAME(a_emit_free, o_cmd.emit, !i_sts.out_full, "result emitted into full slot")
    `MMIS_ASSERT_NEXT(a_accept_disp, o_cmd.capture, r_state == S_DISP, "accept not dispatched")
endmodule

FILE: rtl/mmis_dpath.sv
// Datapath: program store, data memory, execution logic and output register.
module mmis_dpath
    import mmis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_operation,
    input  logic [3:0]  i_opcode,
    input  logic [9:0]  i_field_a,
    input  logic [31:0] i_field_b,
    input  logic [7:0]  i_field_c,
    input  logic [31:0] i_read_value,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [31:0] o_print_value,
    output logic        o_print_valid,
    output logic [1:0]  o_status,
    output logic [9:0]  o_program_counter
);
    logic [1:0]  r_operation;
    t_instr      r_item, r_instr;
    logic [31:0] r_rv;
    logic [PC_W-1:0] r_len, r_pc;
    logic [31:0] r_pval;
    logic        r_pvalid;
    logic [1:0]  r_status;
    logic [31:0] r_xraw, r_yraw;
    logic        r_xv, r_yv;
    logic        r_ov;
    logic [31:0] r_opv;
    logic        r_opvd;
    logic [1:0]  r_ost;
    logic [9:0]  r_opc;

    t_instr      prog_mem [PROGRAM_WORDS];
    logic [31:0] data_mem [DATA_WORDS];
    logic [DATA_WORDS-1:0] r_dvalid;

    logic [31:0] x, y, wval, pow_sp, iter_res;
    logic [DA_W-1:0] rd_a, da;
    logic        we, is_div, is_pow, pow_easy, iter_done, jump, taken;
    logic signed [TGT_W-1:0] tgt;

    assign x      = r_xv ? r_xraw : 32'd0;
    assign y      = r_yv ? r_yraw : 32'd0;
    assign da     = addr_of(r_instr.a[7:0]);
    assign rd_a   = (r_instr.op == OPC_PRINT) ? da : addr_of(r_instr.b[7:0]);
    assign is_div = (r_instr.op == OPC_DIV);
    assign is_pow = (r_instr.op == OPC_POW);
    assign pow_easy = (y == 32'd0) || (x == 32'd1) || (x == 32'hFFFF_FFFF)
                      || y[31] || (x == 32'd0);

    always_comb begin
        if (y == 32'd0 || x == 32'd1) begin
            pow_sp = 32'd1;
        end else if (x == 32'hFFFF_FFFF) begin
            pow_sp = y[0] ? 32'hFFFF_FFFF : 32'd1;
        end else begin
            pow_sp = 32'd0;
        end
    end

    always_comb begin
        we   = 1'b1;
        jump = 1'b0;
        wval = 32'd0;
        case (r_instr.op)
            OPC_ADD:   wval = x + y;
            OPC_SUB:   wval = x - y;
            OPC_MUL:   wval = x * y;
            OPC_DIV:   wval = (y == 32'd0) ? 32'd0 : iter_res;
            OPC_POW:   wval = pow_easy ? pow_sp : iter_res;
            OPC_READ:  wval = r_rv;
            OPC_STORE: wval = r_instr.b;
            OPC_PRINT: we = 1'b0;
            OPC_JUMP: begin
                we = 1'b0;
                jump = 1'b1;
            end
            OPC_JEQ: begin
                we = 1'b0;
                jump = (x == y);
            end
            default:   we = 1'b0;
        endcase
        tgt   = TGT_W'($signed({1'b0, r_pc})) + TGT_W'($signed(r_instr.a));
        taken = jump && (tgt > 0) && (tgt < TGT_W'($signed({1'b0, r_len})));
    end

    mmis_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.iter_start),
        .i_is_pow (is_pow),
        .i_x      (x),
        .i_y      (y),
        .o_done   (iter_done),
        .o_result (iter_res)
    );

    // Program store: one write port for loads, one registered read for fetch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.simple && r_operation == OPN_LOAD && r_len < PC_W'(PROGRAM_WORDS)) begin
            prog_mem[r_len[PA_W-1:0]] <= r_item;
        end
        if (i_cmd.fetch) begin
            r_instr <= prog_mem[r_pc[PA_W-1:0]];
        end
    end

    // Data memory: two registered reads, one write; never-written words read as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) begin
            data_mem[da] <= wval;
        end
        if (i_cmd.rdops) begin
            r_xraw <= data_mem[rd_a];
            r_yraw <= data_mem[addr_of(r_instr.c)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvalid <= '0;
        end else begin
            if (i_cmd.exec && we) begin
                r_dvalid[da] <= 1'b1;
            end
            if (i_cmd.rdops) begin
                r_xv <= r_dvalid[rd_a];
                r_yv <= r_dvalid[addr_of(r_instr.c)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_operation <= i_operation;
            r_item      <= '{c: i_field_c, b: i_field_b, a: i_field_a, op: i_opcode};
            r_rv        <= i_read_value;
        end
        if (i_cmd.fetch) begin
            r_pval   <= 32'd0;
            r_pvalid <= 1'b0;
            r_status <= ST_OK;
        end
        if (i_cmd.simple) begin
            r_pval   <= 32'd0;
            r_pvalid <= 1'b0;
            if (r_operation == OPN_LOAD) begin
                r_status <= (r_len < PC_W'(PROGRAM_WORDS)) ? ST_OK : ST_FULL;
            end else if (r_operation == OPN_STEP) begin
                r_status <= ST_HALTED;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.exec) begin
            if (r_instr.op == OPC_PRINT) begin
                r_pval   <= x;
                r_pvalid <= 1'b1;
            end
            if (is_div && y == 32'd0) begin
                r_status <= ST_DIV0;
            end
        end
        if (i_cmd.emit) begin
            r_opv  <= r_pval;
            r_opvd <= r_pvalid;
            r_ost  <= r_status;
            r_opc  <= 10'(r_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_pc  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cmd.simple) begin
                case (r_operation)
                    OPN_LOAD: begin
                        if (r_len < PC_W'(PROGRAM_WORDS)) begin
                            r_len <= r_len + 1'b1;
                        end
                    end
                    OPN_REWIND: r_pc <= '0;
                    OPN_CLEAR: begin
                        r_pc  <= '0;
                        r_len <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                r_pc <= taken ? tgt[PC_W-1:0] : r_pc + 1'b1;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts = '{operation:  r_operation,
                     halted:     (r_pc >= r_len),
                     needs_iter: (is_div && y != 32'd0) || (is_pow && !pow_easy),
                     iter_done:  iter_done,
                     out_full:   r_ov && !i_out_ready};

    assign o_out_valid       = r_ov;
    assign o_print_value     = r_opv;
    assign o_print_valid     = r_opvd;
    assign o_status          = r_ost;
    assign o_program_counter = r_opc;
endmodule

FILE: rtl/memory_to_memory_instruction_stepper.sv
// Top level of the memory-to-memory instruction stepper.
// Usage: items arrive on the s_axis channel; the operation (load, step, rewind,
// clear) rides in tuser and the instruction and read value in tdata. Every
// item gives exactly one result on the m_axis channel, carrying the printed
// word, its flag in tuser, a status code and the program counter.
// Sequence: a load, rewind, clear or halted step goes from acceptance through
// dispatch to the result; an ordinary step also fetches the instruction, reads
// its operands and executes. A division by a nonzero divisor runs a restoring
// divider one quotient bit a cycle; a power with no special case runs a
// multiply and a range check each step.
// The block works on one item at a time; the next item can be taken in the same
// cycle as the previous result appears, so throughput is set by the divider and the
// power loop for those opcodes.
// The result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, the block holds the finished
// result of the following item until the register frees up.
// Reset clears the program counter, the program length and the written marks
// of the data memory, so all data words read as zero at once; no clearing pass.
module memory_to_memory_instruction_stepper
    import mmis_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[3:0], field_a[13:4], field_b[45:14], field_c[53:46],
    // read_value[85:54], zero padding[87:86]
    input  logic [87:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // print_value[31:0], status[33:32], program_counter[43:34], zero padding[47:44]
    output logic [47:0] m_axis_tdata,
    // print_valid[0]
    output logic        m_axis_tuser
);
    t_cmd        cmd;
    t_sts        sts;
    logic [31:0] print_value;
    logic [1:0]  status;
    logic [9:0]  program_counter;

    mmis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mmis_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_operation       (s_axis_tuser),
        .i_opcode          (s_axis_tdata[3:0]),
        .i_field_a         (s_axis_tdata[13:4]),
        .i_field_b         (s_axis_tdata[45:14]),
        .i_field_c         (s_axis_tdata[53:46]),
        .i_read_value      (s_axis_tdata[85:54]),
        .i_out_ready       (m_axis_tready),
        .o_out_valid       (m_axis_tvalid),
        .o_print_value     (print_value),
        .o_print_valid     (m_axis_tuser),
        .o_status          (status),
        .o_program_counter (program_counter)
    );

    assign m_axis_tdata = {4'd0, program_counter, status, print_value};
endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the memory-to-memory instruction stepper.
module tb_top;
    import mmis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  opcode;
        logic [9:0]  field_a;
        logic [31:0] field_b;
        logic [7:0]  field_c;
        logic [31:0] read_value;
    } t_item;

    typedef struct packed {
        logic [31:0] print_value;
        logic        print_valid;
        logic [1:0]  status;
        logic [9:0]  pc;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [87:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;

    memory_to_memory_instruction_stepper dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The bench's own copy of the machine state.
    logic [31:0] mem_words [DATA_WORDS];
    t_instr      prog_words [PROGRAM_WORDS];
    int unsigned prog_len;
    int unsigned step_pc;

    t_item   pending_items [$];
    t_result expected_results [$];
    int      errors = 0;
    bit      quiet_tail = 1'b0;
    bit      stim_done = 1'b0;

    // Saturating integer power, with the special bases handled first.
    function automatic logic [31:0] sat_power(input int signed base, input int signed ex);
        longint signed r;
        bit neg;
        r = 1;
        if (ex == 0) return 32'd1;
        if (base == 1) return 32'd1;
        if (base == -1) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
        if (ex < 0 || base == 0) return 32'd0;
        neg = (base < 0) && ex[0];
        for (int i = 0; i < ex; i++) begin
            r = r * base;
            if (r > 64'sd2147483647 || r < -64'sd2147483648)
                return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r[31:0];
    endfunction

    // Works out the result of one accepted item and advances the copy of the state.
    function automatic t_result run_item(input t_item it);
        t_result res;
        t_instr  ins;
        logic [31:0] x, y;
        int signed n, d, offs, target;
        bit jump;
        res = '0;
        jump = 1'b0;
        case (it.operation)
            OPN_LOAD: begin
                if (prog_len < PROGRAM_WORDS) begin
                    prog_words[prog_len] = '{c: it.field_c, b: it.field_b,
                                             a: it.field_a, op: it.opcode};
                    prog_len++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OPN_STEP: begin
                if (step_pc >= prog_len) begin
                    res.status = ST_HALTED;
                end else begin
                    ins = prog_words[step_pc];
                    x = mem_words[ins.b[7:0]];
                    y = mem_words[ins.c];
                    offs = $signed(ins.a);
                    target = int'(step_pc) + offs;
                    case (ins.op)
                        OPC_ADD: mem_words[ins.a[7:0]] = x + y;
                        OPC_SUB: mem_words[ins.a[7:0]] = x - y;
                        OPC_MUL: mem_words[ins.a[7:0]] = x * y;
                        OPC_DIV: begin
                            n = $signed(x);
                            d = $signed(y);
                            if (d == 0) begin
                                mem_words[ins.a[7:0]] = '0;
                                res.status = ST_DIV0;
                            end else if (x == 32'h8000_0000 && d == -1) begin
                                mem_words[ins.a[7:0]] = 32'h8000_0000;
                            end else begin
                                mem_words[ins.a[7:0]] = n / d;
                            end
                        end
                        OPC_POW:   mem_words[ins.a[7:0]] = sat_power($signed(x), $signed(y));
                        OPC_READ:  mem_words[ins.a[7:0]] = it.read_value;
                        OPC_PRINT: begin
                            res.print_value = mem_words[ins.a[7:0]];
                            res.print_valid = 1'b1;
                        end
                        OPC_STORE: mem_words[ins.a[7:0]] = ins.b;
                        OPC_JUMP:  jump = 1'b1;
                        OPC_JEQ:   jump = (x == y);
                        default: ;
                    endcase
                    if (jump && target > 0 && target < int'(prog_len))
                        step_pc = target;
                    else
                        step_pc = step_pc + 1;
                end
            end
            OPN_REWIND: step_pc = 0;
            default: begin
                prog_len = 0;
                step_pc = 0;
            end
        endcase
        res.pc = step_pc[9:0];
        return res;
    endfunction

    // Small addresses keep the random programs working on a shared set of words.
    function automatic t_item rand_instr(input bit bounded);
        t_item it;
        it = '0;
        it.operation  = OPN_LOAD;
        it.opcode     = bounded ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 15));
        it.field_a    = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
        it.field_b    = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
        if (it.opcode == OPC_STORE && $urandom_range(0, 1))
            it.field_b = $urandom_range(0, 1) ? 32'($signed(-$urandom_range(0, 3))) :
                         32'($urandom_range(0, 40));
        if (it.opcode inside {OPC_JUMP, OPC_JEQ} && $urandom_range(0, 1))
            it.field_a = 10'($signed($urandom_range(0, 12)) - 6);
        it.field_c    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        it.read_value = $urandom;
        return it;
    endfunction

    function automatic t_item simple_op(input logic [1:0] opn);
        t_item it;
        it = '0;
        it.operation  = opn;
        it.read_value = $urandom;
        return it;
    endfunction

    function automatic t_item fixed_instr(input logic [3:0] opc, input logic [9:0] a,
                                          input logic [31:0] b, input logic [7:0] c);
        t_item it;
        it = '0;
        it.operation = OPN_LOAD;
        it.opcode = opc;
        it.field_a = a;
        it.field_b = b;
        it.field_c = c;
        return it;
    endfunction

    // Driver: presents queued items, with random bursts of idle cycles.
    int src_idle = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(run_item(t_item'({s_axis_tuser,
                    s_axis_tdata[3:0], s_axis_tdata[13:4], s_axis_tdata[45:14],
                    s_axis_tdata[53:46], s_axis_tdata[85:54]})));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    t_item nxt;
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.operation;
                    s_axis_tdata  <= {2'b00, nxt.read_value, nxt.field_c, nxt.field_b,
                                      nxt.field_a, nxt.opcode};
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        src_idle <= $urandom_range(1, 8);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes results and checks each field against the oldest expectation.
    int sink_idle = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with nothing expected");
                    errors++;
                end else begin
                    t_result want;
                    want = expected_results.pop_front();
                    if (m_axis_tdata[31:0] !== want.print_value) begin
                        $error("print_value expected %h got %h", want.print_value,
                               m_axis_tdata[31:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== want.print_valid) begin
                        $error("print_valid expected %b got %b", want.print_valid, m_axis_tuser);
                        errors++;
                    end
                    if (m_axis_tdata[33:32] !== want.status) begin
                        $error("status expected %0d got %0d", want.status, m_axis_tdata[33:32]);
                        errors++;
                    end
                    if (m_axis_tdata[43:34] !== want.pc) begin
                        $error("program_counter expected %0d got %0d", want.pc,
                               m_axis_tdata[43:34]);
                        errors++;
                    end
                end
            end
            if (sink_idle > 0) begin
                sink_idle <= sink_idle - 1;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
                sink_idle <= $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus: directed programs first, then random programs interleaved with noise.
    initial begin
        int plen;
        for (int i = 0; i < DATA_WORDS; i++) mem_words[i] = '0;
        prog_len = 0;
        step_pc = 0;

        // Directed: step on an empty program, every opcode and the edge values.
        pending_items.push_back(simple_op(OPN_STEP));
        pending_items.push_back(fixed_instr(OPC_STORE, 10'd1, 32'h8000_0000, 8'd0));
        pending_items.push_back(fixed_instr(OPC_STORE, 10'd2, 32'hFFFF_FFFF, 8'd0));
        pending_items.push_back(fixed_instr(OPC_DIV,   10'd3, 32'd1, 8'd2));
        pending_items.push_back(fixed_instr(OPC_DIV,   10'd4, 32'd1, 8'd0));
        pending_items.push_back(fixed_instr(OPC_POW,   10'd5, 32'd2, 8'd2));
        pending_items.push_back(fixed_instr(OPC_POW,   10'd6, 32'd1, 8'd0));
        pending_items.push_back(fixed_instr(OPC_ADD,   10'h3FF, 32'hFFFF_FF01, 8'd255));
        pending_items.push_back(fixed_instr(OPC_SUB,   10'd7, 32'd1, 8'd2));
        pending_items.push_back(fixed_instr(OPC_MUL,   10'd8, 32'd1, 8'd1));
        pending_items.push_back(fixed_instr(OPC_READ,  10'd9, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(OPC_PRINT, 10'd9, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(OPC_JEQ,   10'd2, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(4'd15,     10'd0, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(OPC_JUMP,  10'h200, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(OPC_JUMP,  10'h1FF, 32'd0, 8'd0));
        pending_items.push_back(fixed_instr(OPC_JUMP,  10'h3F1, 32'd0, 8'd0));
        for (int i = 0; i < 18; i++) begin
            t_item s;
            s = simple_op(OPN_STEP);
            s.read_value = (i == 9) ? 32'h7FFF_FFFF : $urandom;
            pending_items.push_back(s);
        end
        pending_items.push_back(simple_op(OPN_REWIND));

        // Fill the program store to capacity and two loads beyond.
        pending_items.push_back(simple_op(OPN_CLEAR));
        for (int i = 0; i < PROGRAM_WORDS + 2; i++)
            pending_items.push_back(rand_instr(1'b1));
        for (int i = 0; i < 40; i++)
            pending_items.push_back(simple_op(OPN_STEP));

        // Random programs: short loads, then mostly steps, with occasional noise.
        while (pending_items.size() < 1250) begin
            pending_items.push_back(simple_op(OPN_CLEAR));
            plen = $urandom_range(2, 12);
            for (int i = 0; i < plen; i++)
                pending_items.push_back(rand_instr($urandom_range(0, 7) != 0));
            for (int i = 0; i < 3 * plen; i++) begin
                case ($urandom_range(0, 19))
                    0:       pending_items.push_back(simple_op(OPN_REWIND));
                    1:       pending_items.push_back(rand_instr(1'b0));
                    default: pending_items.push_back(simple_op(OPN_STEP));
                endcase
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() < 60);
        quiet_tail = 1'b1;
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Run limit: generous against the slowest case of every item.
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Verification failed");
            $finish;
        end
    end
endmodule
